FILE: hdl/mvfm_pkg.sv
package mvfm_pkg;

	// register map
	localparam logic [2:0] REG_ENABLE       = 3'd0;
	localparam logic [2:0] REG_WAIT_TICKS   = 3'd1;
	localparam logic [2:0] REG_WINDOW_TICKS = 3'd2;
	localparam logic [2:0] REG_CLEAR_LOW    = 3'd3;
	localparam logic [2:0] REG_CLEAR_HIGH   = 3'd4;
	localparam logic [2:0] REG_TRIP_HIGH    = 3'd5;
	localparam logic [2:0] REG_TRIP_LOW     = 3'd6;
	localparam logic [2:0] REG_CONFIRM      = 3'd7;

	localparam int IDX_BITS    = 3;
	localparam int DATA_BITS   = 16;
	localparam int TICK_BITS   = 16;
	localparam int WINDOW_BITS = 8;
	localparam int THR_BITS    = 10;
	localparam int STREAK_BITS = 2;

	// reset values of the registers
	localparam logic [TICK_BITS-1:0]   RST_WAIT_TICKS   = 16'd7000;
	localparam logic [WINDOW_BITS-1:0] RST_WINDOW_TICKS = 8'd16;
	localparam logic [THR_BITS-1:0]    RST_CLEAR_LOW    = 10'd200;
	localparam logic [THR_BITS-1:0]    RST_CLEAR_HIGH   = 10'd400;
	localparam logic [THR_BITS-1:0]    RST_TRIP_HIGH    = 10'd400;
	localparam logic [THR_BITS-1:0]    RST_TRIP_LOW     = 10'd210;
	localparam logic [STREAK_BITS-1:0] RST_CONFIRM      = 2'd2;

	localparam logic [TICK_BITS-1:0]   TICK_MAX   = '1;
	localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;

	// item kinds
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef logic [1:0] fault_ev_t;
	localparam fault_ev_t EV_NONE    = 2'd0;
	localparam fault_ev_t EV_RAISED  = 2'd1;
	localparam fault_ev_t EV_CLEARED = 2'd2;

endpackage

FILE: hdl/mains_voltage_fault_monitor_unit.sv
// a word accepted into the input register moves on to the result register once that register is free
// throughput: one word per cycle while out_ready keeps the result register free; the state update is a single pass of
//   counter and threshold compare logic between the input and result registers
// reset: arst_n clears the valid flags and monitor state at once, restores register defaults, safe high
// results wait in the output register while the next word is taken
module mains_voltage_fault_monitor_unit #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [mvfm_pkg::IDX_BITS-1:0]       wr_index,
	input  logic [mvfm_pkg::DATA_BITS-1:0]      wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic [SAMPLE_BITS-1:0]              adc_sample,
	input  logic                                load_safe,
	input  logic                                temp_safe,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                sampling,
	output logic                                safe,
	output logic                                fault,
	output logic [1:0]                          fault_event
);

	localparam int CMP_BITS = (SAMPLE_BITS > mvfm_pkg::THR_BITS) ? SAMPLE_BITS
		: mvfm_pkg::THR_BITS;

	// configuration
	logic                                 enable_q;
	logic [mvfm_pkg::TICK_BITS-1:0]       wait_ticks_q;
	logic [mvfm_pkg::WINDOW_BITS-1:0]     window_ticks_q;
	logic [mvfm_pkg::THR_BITS-1:0]        clear_low_q, clear_high_q;
	logic [mvfm_pkg::THR_BITS-1:0]        trip_high_q, trip_low_q;
	logic [mvfm_pkg::STREAK_BITS-1:0]     confirm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b1;
			wait_ticks_q   <= mvfm_pkg::RST_WAIT_TICKS;
			window_ticks_q <= mvfm_pkg::RST_WINDOW_TICKS;
			clear_low_q    <= mvfm_pkg::RST_CLEAR_LOW;
			clear_high_q   <= mvfm_pkg::RST_CLEAR_HIGH;
			trip_high_q    <= mvfm_pkg::RST_TRIP_HIGH;
			trip_low_q     <= mvfm_pkg::RST_TRIP_LOW;
			confirm_q      <= mvfm_pkg::RST_CONFIRM;
		end else if (wr_en) begin
			case (wr_index)
				mvfm_pkg::REG_ENABLE:       enable_q       <= wr_data[0];
				mvfm_pkg::REG_WAIT_TICKS:   wait_ticks_q   <= wr_data[mvfm_pkg::TICK_BITS-1:0];
				mvfm_pkg::REG_WINDOW_TICKS: window_ticks_q <= wr_data[mvfm_pkg::WINDOW_BITS-1:0];
				mvfm_pkg::REG_CLEAR_LOW:    clear_low_q    <= wr_data[mvfm_pkg::THR_BITS-1:0];
				mvfm_pkg::REG_CLEAR_HIGH:   clear_high_q   <= wr_data[mvfm_pkg::THR_BITS-1:0];
				mvfm_pkg::REG_TRIP_HIGH:    trip_high_q    <= wr_data[mvfm_pkg::THR_BITS-1:0];
				mvfm_pkg::REG_TRIP_LOW:     trip_low_q     <= wr_data[mvfm_pkg::THR_BITS-1:0];
				mvfm_pkg::REG_CONFIRM:      confirm_q      <= wr_data[mvfm_pkg::STREAK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	logic                   valid_s1;
	logic                   cmd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   load_safe_s1, temp_safe_s1;
	logic                   advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1       <= cmd;
			sample_s1    <= adc_sample;
			load_safe_s1 <= load_safe;
			temp_safe_s1 <= temp_safe;
		end
	end

	// monitor state
	logic [mvfm_pkg::TICK_BITS-1:0]   tick_q;
	logic                             window_q;
	logic [SAMPLE_BITS-1:0]           peak_q;
	logic [mvfm_pkg::STREAK_BITS-1:0] streak_q;
	logic                             fault_q;
	logic                             safe_q;

	logic [mvfm_pkg::TICK_BITS-1:0]   tick_d, tick_inc;
	logic                             window_d;
	logic [SAMPLE_BITS-1:0]           peak_d;
	logic [mvfm_pkg::STREAK_BITS-1:0] streak_d, streak_inc;
	logic                             fault_d, safe_d;
	mvfm_pkg::fault_ev_t              ev_d;
	logic [CMP_BITS-1:0]              peak_x;
	logic                             qualify, hit;

	always_comb begin
		tick_inc   = (tick_q == mvfm_pkg::TICK_MAX) ? tick_q : tick_q + 1'b1;
		streak_inc = (streak_q == mvfm_pkg::STREAK_MAX) ? streak_q : streak_q + 1'b1;
		hit        = streak_inc >= confirm_q;
		peak_x     = CMP_BITS'(peak_q);
		if (fault_q) begin
			qualify = (peak_x <= CMP_BITS'(clear_high_q)) && (peak_x >= CMP_BITS'(clear_low_q));
		end else begin
			qualify = (peak_x >= CMP_BITS'(trip_high_q)) || (peak_x <= CMP_BITS'(trip_low_q));
		end

		tick_d   = tick_q;
		window_d = window_q;
		peak_d   = peak_q;
		streak_d = streak_q;
		fault_d  = fault_q;
		safe_d   = safe_q;
		ev_d     = mvfm_pkg::EV_NONE;

		if (cmd_s1 == mvfm_pkg::CMD_SAMPLE) begin
			if (window_q && (peak_q < sample_s1)) begin
				peak_d = sample_s1;
			end
		end else if (enable_q) begin
			tick_d = tick_inc;
			if (!window_q) begin
				if (tick_inc >= wait_ticks_q) begin
					if (load_safe_s1 && temp_safe_s1) begin
						tick_d   = '0;
						window_d = 1'b1;
						safe_d   = 1'b0;
					end else begin
						tick_d = wait_ticks_q;
					end
				end
			end else if (tick_inc >= mvfm_pkg::TICK_BITS'(window_ticks_q)) begin
				// window closes: judge the peak
				tick_d   = '0;
				window_d = 1'b0;
				peak_d   = '0;
				if (!qualify) begin
					streak_d = '0;
				end else if (hit) begin
					streak_d = '0;
					fault_d  = !fault_q;
					ev_d     = fault_q ? mvfm_pkg::EV_CLEARED : mvfm_pkg::EV_RAISED;
				end else begin
					streak_d = streak_inc;
				end
				if (!fault_d) begin
					safe_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			window_q <= 1'b0;
			peak_q   <= '0;
			streak_q <= '0;
			fault_q  <= 1'b0;
			safe_q   <= 1'b1;
		end else if (advance) begin
			tick_q   <= tick_d;
			window_q <= window_d;
			peak_q   <= peak_d;
			streak_q <= streak_d;
			fault_q  <= fault_d;
			safe_q   <= safe_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sampling    <= window_d;
			safe        <= safe_d;
			fault       <= fault_d;
			fault_event <= ev_d;
		end
	end

`ifndef SYNTHESIS
	a_raise_sets_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_event == mvfm_pkg::EV_RAISED) |-> fault)
		else $error("fault raised word without fault latched");

	a_clear_restores_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (fault_event == mvfm_pkg::EV_CLEARED) |-> !fault && safe)
		else $error("fault cleared word without safe restored");

	a_window_drops_safe: assert property (@(posedge clk) disable iff (!arst_n)
		window_q |-> !safe_q)
		else $error("safe high while sampling window open");

	a_peak_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!window_q |-> (peak_q == '0))
		else $error("peak held outside sampling window");
`endif

endmodule

FILE: verif/tb_mains_voltage_fault_monitor_unit.sv
module tb_mains_voltage_fault_monitor_unit;

	localparam int SMP_BITS = 10;

	typedef struct packed {
		logic                cmd;
		logic [SMP_BITS-1:0] sample;
		logic                load_safe;
		logic                temp_safe;
	} word_t;

	typedef struct packed {
		logic                sampling;
		logic                safe;
		logic                fault;
		mvfm_pkg::fault_ev_t ev;
	} status_t;

	typedef struct {
		bit                             is_reg;
		logic [mvfm_pkg::IDX_BITS-1:0]  idx;
		logic [mvfm_pkg::DATA_BITS-1:0] data;
		word_t                          w;
		bit                             has_lit;
		status_t                        lit;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           wr_en = 1'b0;
	logic [mvfm_pkg::IDX_BITS-1:0]  wr_index = '0;
	logic [mvfm_pkg::DATA_BITS-1:0] wr_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           cmd = mvfm_pkg::CMD_SAMPLE;
	logic [SMP_BITS-1:0]            adc_sample = '0;
	logic                           load_safe = 1'b0;
	logic                           temp_safe = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           sampling;
	logic                           safe;
	logic                           fault;
	logic [1:0]                     fault_event;

	// register copies
	bit                               cf_enable = 1'b1;
	logic [mvfm_pkg::TICK_BITS-1:0]   cf_wait = mvfm_pkg::RST_WAIT_TICKS;
	logic [mvfm_pkg::WINDOW_BITS-1:0] cf_window = mvfm_pkg::RST_WINDOW_TICKS;
	logic [mvfm_pkg::THR_BITS-1:0]    cf_clear_lo = mvfm_pkg::RST_CLEAR_LOW;
	logic [mvfm_pkg::THR_BITS-1:0]    cf_clear_hi = mvfm_pkg::RST_CLEAR_HIGH;
	logic [mvfm_pkg::THR_BITS-1:0]    cf_trip_hi = mvfm_pkg::RST_TRIP_HIGH;
	logic [mvfm_pkg::THR_BITS-1:0]    cf_trip_lo = mvfm_pkg::RST_TRIP_LOW;
	logic [mvfm_pkg::STREAK_BITS-1:0] cf_confirm = mvfm_pkg::RST_CONFIRM;

	// monitor state as predicted
	logic [mvfm_pkg::TICK_BITS-1:0]   st_ticks = '0;
	bit                               st_open = 1'b0;
	logic [SMP_BITS-1:0]              st_peak = '0;
	logic [mvfm_pkg::STREAK_BITS-1:0] st_streak = '0;
	bit                               st_fault = 1'b0;
	bit                               st_safe = 1'b1;

	status_t status_due[$];
	row_t    plan[$];
	int      mismatch_cnt = 0;
	bit      src_idle = 1'b1;
	bit      sink_idle = 1'b1;
	bit      hold_req = 1'b0;

	mains_voltage_fault_monitor_unit #(.SAMPLE_BITS(SMP_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.adc_sample(adc_sample),
		.load_safe(load_safe),
		.temp_safe(temp_safe),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sampling(sampling),
		.safe(safe),
		.fault(fault),
		.fault_event(fault_event)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic status_t advance_monitor(word_t w);
		status_t             r;
		mvfm_pkg::fault_ev_t ev;
		bit                  qualify;
		ev = mvfm_pkg::EV_NONE;
		if (w.cmd == mvfm_pkg::CMD_SAMPLE) begin
			if (st_open && st_peak < w.sample)
				st_peak = w.sample;
		end else if (cf_enable) begin
			if (st_ticks != mvfm_pkg::TICK_MAX)
				st_ticks = st_ticks + 1'b1;
			if (!st_open) begin
				if (st_ticks >= cf_wait) begin
					if (w.load_safe && w.temp_safe) begin
						st_ticks = '0;
						st_open = 1'b1;
						st_safe = 1'b0;
					end else begin
						st_ticks = cf_wait;
					end
				end
			end else if (st_ticks >= cf_window) begin
				// window closes: judge the peak against the band for the current state
				st_ticks = '0;
				st_open = 1'b0;
				if (st_fault)
					qualify = st_peak <= cf_clear_hi && st_peak >= cf_clear_lo;
				else
					qualify = st_peak >= cf_trip_hi || st_peak <= cf_trip_lo;
				if (!qualify) begin
					st_streak = '0;
				end else begin
					if (st_streak != mvfm_pkg::STREAK_MAX)
						st_streak = st_streak + 1'b1;
					if (st_streak >= cf_confirm) begin
						st_streak = '0;
						st_fault = !st_fault;
						ev = st_fault ? mvfm_pkg::EV_RAISED : mvfm_pkg::EV_CLEARED;
					end
				end
				if (!st_fault)
					st_safe = 1'b1;
				st_peak = '0;
			end
		end
		r = {st_open, st_safe, st_fault, ev};
		return r;
	endfunction

	function automatic word_t pick_word();
		word_t       w;
		int unsigned pick;
		logic [SMP_BITS-1:0] centre;
		pick = $urandom_range(0, 99);
		w.cmd = (st_open ? pick < 55 : pick < 10) ? mvfm_pkg::CMD_SAMPLE : mvfm_pkg::CMD_TICK;
		w.load_safe = $urandom_range(0, 7) != 0;
		w.temp_safe = $urandom_range(0, 7) != 0;
		// aim most samples at the band edges
		case ($urandom_range(0, 5))
			0: centre = cf_trip_hi;
			1: centre = cf_trip_lo;
			2: centre = cf_clear_lo;
			3: centre = cf_clear_hi;
			default: centre = SMP_BITS'($urandom);
		endcase
		w.sample = centre + SMP_BITS'($urandom_range(0, 2)) - 1'b1;
		if (pick >= 90)
			w = word_t'($urandom);
		return w;
	endfunction

	function automatic row_t word_row(logic c, logic [SMP_BITS-1:0] s, logic ls, logic ts);
		row_t r;
		r.is_reg = 1'b0;
		r.idx = '0;
		r.data = '0;
		r.w = {c, s, ls, ts};
		r.has_lit = 1'b0;
		r.lit = '0;
		return r;
	endfunction

	function automatic row_t checked_row(logic c, logic [SMP_BITS-1:0] s, logic ls, logic ts,
			status_t lit);
		row_t r;
		r = word_row(c, s, ls, ts);
		r.has_lit = 1'b1;
		r.lit = lit;
		return r;
	endfunction

	function automatic row_t reg_row(logic [mvfm_pkg::IDX_BITS-1:0] idx,
			logic [mvfm_pkg::DATA_BITS-1:0] data);
		row_t r;
		r = word_row(mvfm_pkg::CMD_SAMPLE, '0, 1'b0, 1'b0);
		r.is_reg = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
	endfunction

	// all tasks below start and end at a falling edge
	task automatic push_word(word_t w, bit has_lit, status_t lit);
		status_t due;
		cmd <= w.cmd;
		adc_sample <= w.sample;
		load_safe <= w.load_safe;
		temp_safe <= w.temp_safe;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		due = advance_monitor(w);
		status_due.push_back(has_lit ? lit : due);
		@(negedge clk);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (status_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [mvfm_pkg::IDX_BITS-1:0] idx,
			logic [mvfm_pkg::DATA_BITS-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			mvfm_pkg::REG_ENABLE:       cf_enable = data[0];
			mvfm_pkg::REG_WAIT_TICKS:   cf_wait = data[mvfm_pkg::TICK_BITS-1:0];
			mvfm_pkg::REG_WINDOW_TICKS: cf_window = data[mvfm_pkg::WINDOW_BITS-1:0];
			mvfm_pkg::REG_CLEAR_LOW:    cf_clear_lo = data[mvfm_pkg::THR_BITS-1:0];
			mvfm_pkg::REG_CLEAR_HIGH:   cf_clear_hi = data[mvfm_pkg::THR_BITS-1:0];
			mvfm_pkg::REG_TRIP_HIGH:    cf_trip_hi = data[mvfm_pkg::THR_BITS-1:0];
			mvfm_pkg::REG_TRIP_LOW:     cf_trip_lo = data[mvfm_pkg::THR_BITS-1:0];
			mvfm_pkg::REG_CONFIRM:      cf_confirm = data[mvfm_pkg::STREAK_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_due.size() == 0) begin
				note_mismatch("unexpected word", 0, {sampling, safe, fault, fault_event});
			end else begin
				want = status_due.pop_front();
				if (sampling !== want.sampling)
					note_mismatch("sampling", want.sampling, sampling);
				if (safe !== want.safe)
					note_mismatch("safe", want.safe, safe);
				if (fault !== want.fault)
					note_mismatch("fault", want.fault, fault);
				if (fault_event !== want.ev)
					note_mismatch("fault_event", want.ev, fault_event);
			end
		end
	end

	initial begin : sink
		int hold;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// long hold-off so the block backs up and stops taking words
				out_ready <= 1'b0;
				hold = 60;
				while (hold > 0) begin
					@(negedge clk);
					hold--;
				end
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int n;
		int guard;
		plan.push_back(checked_row(mvfm_pkg::CMD_SAMPLE, 10'd1023, 1'b0, 1'b0,
			{1'b0, 1'b1, 1'b0, mvfm_pkg::EV_NONE}));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b0, 1'b1, 1'b0, mvfm_pkg::EV_NONE}));
		plan.push_back(reg_row(mvfm_pkg::REG_WAIT_TICKS, 16'd1));
		plan.push_back(reg_row(mvfm_pkg::REG_WINDOW_TICKS, 16'd2));
		plan.push_back(reg_row(mvfm_pkg::REG_CONFIRM, 16'd1));
		// count held at the limit while only one flag is safe
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b0,
			{1'b0, 1'b1, 1'b0, mvfm_pkg::EV_NONE}));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b1, 1'b0, 1'b0, mvfm_pkg::EV_NONE}));
		plan.push_back(word_row(mvfm_pkg::CMD_SAMPLE, 10'd1023, 1'b0, 1'b0));
		plan.push_back(word_row(mvfm_pkg::CMD_SAMPLE, 10'd5, 1'b1, 1'b1));
		plan.push_back(word_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b0, 1'b0,
			{1'b0, 1'b0, 1'b1, mvfm_pkg::EV_RAISED}));
		// sample with no window open is dropped
		plan.push_back(checked_row(mvfm_pkg::CMD_SAMPLE, 10'd300, 1'b0, 1'b0,
			{1'b0, 1'b0, 1'b1, mvfm_pkg::EV_NONE}));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b1, 1'b0, 1'b1, mvfm_pkg::EV_NONE}));
		plan.push_back(word_row(mvfm_pkg::CMD_SAMPLE, 10'd300, 1'b0, 1'b0));
		plan.push_back(word_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b0, 1'b1, 1'b0, mvfm_pkg::EV_CLEARED}));
		plan.push_back(word_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1));
		// disabled: ticks do nothing but samples still reach the peak
		plan.push_back(reg_row(mvfm_pkg::REG_ENABLE, 16'd0));
		plan.push_back(word_row(mvfm_pkg::CMD_SAMPLE, 10'd0, 1'b1, 1'b1));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b1, 1'b0, 1'b0, mvfm_pkg::EV_NONE}));
		plan.push_back(reg_row(mvfm_pkg::REG_ENABLE, 16'd1));
		plan.push_back(word_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b0, 1'b1));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b0, 1'b1,
			{1'b0, 1'b0, 1'b1, mvfm_pkg::EV_RAISED}));
		// zero wait, zero window, zero confirm count
		plan.push_back(reg_row(mvfm_pkg::REG_WINDOW_TICKS, 16'd0));
		plan.push_back(reg_row(mvfm_pkg::REG_WAIT_TICKS, 16'd0));
		plan.push_back(reg_row(mvfm_pkg::REG_CONFIRM, 16'd0));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b0, 1'b1,
			{1'b0, 1'b0, 1'b1, mvfm_pkg::EV_NONE}));
		plan.push_back(word_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b0, 1'b0, 1'b1, mvfm_pkg::EV_NONE}));
		plan.push_back(reg_row(mvfm_pkg::REG_CLEAR_LOW, 16'd0));
		plan.push_back(word_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1));
		plan.push_back(word_row(mvfm_pkg::CMD_SAMPLE, 10'd341, 1'b0, 1'b0));
		plan.push_back(checked_row(mvfm_pkg::CMD_TICK, 10'd0, 1'b1, 1'b1,
			{1'b0, 1'b1, 1'b0, mvfm_pkg::EV_CLEARED}));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain_results();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				push_word(plan[i].w, plan[i].has_lit, plan[i].lit);
			end
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			src_idle = ph != 7;
			sink_idle = ph != 7;
			write_reg(mvfm_pkg::REG_ENABLE, (ph == 5) ? 16'd0 : 16'd1);
			write_reg(mvfm_pkg::REG_WAIT_TICKS,
				(ph == 3) ? 16'd0 : 16'($urandom_range(0, 4)));
			write_reg(mvfm_pkg::REG_WINDOW_TICKS, (ph == 2) ? 16'd255 :
				(ph == 3) ? 16'd0 : 16'($urandom_range(1, 6)));
			write_reg(mvfm_pkg::REG_CONFIRM, 16'(ph % 4));
			if (ph == 3) begin
				// every peak trips and every peak clears
				write_reg(mvfm_pkg::REG_TRIP_HIGH, 16'd0);
				write_reg(mvfm_pkg::REG_TRIP_LOW, 16'd1023);
				write_reg(mvfm_pkg::REG_CLEAR_LOW, 16'd0);
				write_reg(mvfm_pkg::REG_CLEAR_HIGH, 16'd1023);
			end else if (ph == 4) begin
				// only the rails trip, nothing clears
				write_reg(mvfm_pkg::REG_TRIP_HIGH, 16'd1023);
				write_reg(mvfm_pkg::REG_TRIP_LOW, 16'd0);
				write_reg(mvfm_pkg::REG_CLEAR_LOW, 16'd1023);
				write_reg(mvfm_pkg::REG_CLEAR_HIGH, 16'd0);
			end else begin
				write_reg(mvfm_pkg::REG_TRIP_HIGH, 16'($urandom_range(300, 700)));
				write_reg(mvfm_pkg::REG_TRIP_LOW, 16'($urandom_range(100, 300)));
				write_reg(mvfm_pkg::REG_CLEAR_LOW, 16'($urandom_range(100, 300)));
				write_reg(mvfm_pkg::REG_CLEAR_HIGH, 16'($urandom_range(300, 700)));
			end
			if (ph == 1)
				hold_req = 1'b1;
			n = (ph == 2) ? 600 : (ph == 5) ? 60 : 170;
			for (int i = 0; i < n; i++) begin
				if (ph == 6 && i == n / 2)
					drain_results();
				push_word(pick_word(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		guard = 0;
		while (status_due.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (mismatch_cnt == 0 && status_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#25000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/mvfm_pkg.sv
hdl/mains_voltage_fault_monitor_unit.sv
verif/tb_mains_voltage_fault_monitor_unit.sv
